// File: sv/snd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the split-normal density pipeline.
package snd_pkg;

    typedef logic signed [31:0] q16_t;

    localparam logic [29:0] RCAP          = 30'h2000_0000;
    localparam longint      LN2_Q30       = 744261118;
    localparam longint      LN2_Q24       = 11629080;
    localparam longint      HALF_LN_2_PI  = -3788150;
    localparam longint      TINY_LIMIT    = -40 * 11629080;
    localparam longint      HUGE_LIMIT    = 15 * 11629080;
    localparam int          DIV_STEPS     = 30;
    localparam int          LN_LAT        = 33;
    localparam int          EXP_TERMS     = 13;
    localparam int          EXP_LAT       = 3 * 13;
    localparam int          PIPE_LAT      = 85;

endpackage

// File: sv/snd_ln.sv
`timescale 1ns / 1ps
// Pipelined natural logarithm of an unsigned Q31.32 value, result in Q.24.
module snd_ln
(
    input  logic               clk,
    input  logic               en,
    input  logic [62:0]        k_val,
    output logic signed [31:0] ln_val
);

    logic [62:0] nrm_reg [1:6];
    logic [5:0]  cnt_reg [1:6];

    for (genvar j = 1; j <= 6; j++)
    begin : g_norm
        localparam int SH = 1 << (6 - j);
        logic [62:0] src;
        logic [5:0]  csrc;
        if (j == 1)
        begin : g_first
            assign src  = k_val;
            assign csrc = '0;
        end
        else
        begin : g_rest
            assign src  = nrm_reg[j-1];
            assign csrc = cnt_reg[j-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (src[62 -: SH] == '0)
                begin
                    nrm_reg[j] <= src << SH;
                    cnt_reg[j] <= csrc + 6'(SH);
                end
                else
                begin
                    nrm_reg[j] <= src;
                    cnt_reg[j] <= csrc;
                end
            end
        end
    end

    logic [30:0] man_reg  [1:24];
    logic [23:0] frac_reg [1:24];
    logic [5:0]  sc_reg   [1:24];

    for (genvar j = 1; j <= 24; j++)
    begin : g_sq
        logic [30:0] msrc;
        logic [23:0] fsrc;
        logic [5:0]  csrc;
        logic [61:0] sq;
        logic [31:0] m2;
        if (j == 1)
        begin : g_first
            assign msrc = nrm_reg[6][62:32];
            assign fsrc = '0;
            assign csrc = cnt_reg[6];
        end
        else
        begin : g_rest
            assign msrc = man_reg[j-1];
            assign fsrc = frac_reg[j-1];
            assign csrc = sc_reg[j-1];
        end
        assign sq = 62'(msrc) * 62'(msrc);
        assign m2 = sq[61:30];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                man_reg[j]  <= m2[31] ? m2[31:1] : m2[30:0];
                frac_reg[j] <= {fsrc[22:0], m2[31]};
                sc_reg[j]   <= csrc;
            end
        end
    end

    logic signed [31:0] l2_reg;
    logic signed [63:0] prod_reg;
    logic signed [7:0]  ipart;
    logic [63:0]        mag;
    logic [63:0]        rnd;

    assign ipart = 8'sd30 - $signed({2'b00, sc_reg[24]});
    assign mag   = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
    assign rnd   = (mag + 64'h2000_0000) >> 30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l2_reg   <= $signed({ipart, frac_reg[24]});
            prod_reg <= 64'(l2_reg) * 64'(snd_pkg::LN2_Q30);
            ln_val   <= prod_reg[63] ? 32'(-$signed(rnd)) : 32'(rnd);
        end
    end

endmodule

// File: sv/snd_exp.sv
`timescale 1ns / 1ps
// Pipelined Taylor series of e^u for a Q0.30 argument below ln 2.
module snd_exp
(
    input  logic        clk,
    input  logic        en,
    input  logic [29:0] u_val,
    output logic [31:0] sum_val
);

    localparam int NT = snd_pkg::EXP_TERMS;

    logic [30:0] ta_reg   [1:NT];
    logic [31:0] sa_reg   [1:NT];
    logic [29:0] ua_reg   [1:NT];
    logic [30:0] tb_reg   [1:NT];
    logic [30:0] qb_reg   [1:NT];
    logic [31:0] sb_reg   [1:NT];
    logic [29:0] ub_reg   [1:NT];
    logic [30:0] term_reg [1:NT];
    logic [31:0] sum_reg  [1:NT];
    logic [29:0] uc_reg   [1:NT];

    for (genvar k = 1; k <= NT; k++)
    begin : g_term
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / k);
        logic [30:0] tsrc;
        logic [31:0] ssrc;
        logic [29:0] usrc;
        logic [60:0] pa;
        logic [63:0] pb;
        logic [30:0] rmn;
        logic [30:0] qc;
        if (k == 1)
        begin : g_first
            assign tsrc = 31'h4000_0000;
            assign ssrc = 32'h4000_0000;
            assign usrc = u_val;
        end
        else
        begin : g_rest
            assign tsrc = term_reg[k-1];
            assign ssrc = sum_reg[k-1];
            assign usrc = uc_reg[k-1];
        end
        assign pa  = 61'(tsrc) * 61'(usrc);
        assign pb  = 64'(ta_reg[k]) * 64'(RECIP);
        assign rmn = tb_reg[k] - 31'(qb_reg[k] * 31'(k));
        assign qc  = (rmn >= 31'(k)) ? qb_reg[k] + 31'd1 : qb_reg[k];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ta_reg[k]   <= pa[60:30];
                sa_reg[k]   <= ssrc;
                ua_reg[k]   <= usrc;
                tb_reg[k]   <= ta_reg[k];
                qb_reg[k]   <= pb[62:32];
                sb_reg[k]   <= sa_reg[k];
                ub_reg[k]   <= ua_reg[k];
                term_reg[k] <= qc;
                sum_reg[k]  <= sb_reg[k] + 32'(qc);
                uc_reg[k]   <= ub_reg[k];
            end
        end
    end

    assign sum_val = sum_reg[NT];

endmodule

// File: sv/split_normal_density.sv
`timescale 1ns / 1ps
// Split-normal density pipeline: top level with division, control and output stage.
// Throughput is one request per cycle; every restoring-division step, mantissa squaring
// and series term has stages of its own, so only output back-pressure stalls the pipe.
// The whole pipe advances together, so a stall holds every stage in place.
// Reset clears the stage valid bits and sets log_mode to zero.
module split_normal_density
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0: quantile_x, location_mu, scale_sigma, skew_lambda, zero pad.
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0: density_value.
    output logic [31:0]  m_axis_tdata,
    // Fields from bit 0: invalid_args, saturated.
    output logic [1:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);

    localparam int LAT = snd_pkg::PIPE_LAT;
    localparam int ND  = snd_pkg::DIV_STEPS;

    logic             en;
    logic             log_mode_reg;
    logic [LAT:1]     vld_reg;

    assign en            = !vld_reg[LAT] || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = vld_reg[LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            log_mode_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-1:1], s_axis_tvalid};
            end
            if (cfg_valid)
            begin
                log_mode_reg <= cfg_data;
            end
        end
    end

    logic signed [31:0] x1_reg;
    logic signed [31:0] mu1_reg;
    logic [30:0]        sg1_reg;
    logic [30:0]        lm1_reg;
    logic [32:0]        diff2_reg;
    logic [61:0]        dv2_reg;
    logic [30:0]        sg2_reg;
    logic [30:0]        lm2_reg;
    logic               ovf3_reg;
    logic [68:0]        rem3_reg;
    logic [61:0]        dv3_reg;
    logic [62:0]        k3_reg;
    logic               inv_reg [2:LAT-1];
    logic signed [32:0] dxm;
    logic               right;
    logic [61:0]        sl_prod;

    assign dxm     = 33'(x1_reg) - 33'(mu1_reg);
    assign right   = dxm > 0;
    assign sl_prod = 62'(sg1_reg) * 62'(lm1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= s_axis_tdata[31:0];
            mu1_reg   <= s_axis_tdata[63:32];
            sg1_reg   <= s_axis_tdata[94:64];
            lm1_reg   <= s_axis_tdata[125:95];
            diff2_reg <= right ? 33'(dxm) : 33'(-dxm);
            dv2_reg   <= right ? sl_prod : {15'b0, sg1_reg, 16'b0};
            sg2_reg   <= sg1_reg;
            lm2_reg   <= lm1_reg;
            inv_reg[2] <= (sg1_reg == '0) || (lm1_reg == '0);
            ovf3_reg  <= {23'b0, diff2_reg, 6'b0} >= dv2_reg;
            rem3_reg  <= {diff2_reg, 36'b0};
            dv3_reg   <= dv2_reg;
            k3_reg    <= 63'(32'h0001_0000 + 32'(lm2_reg)) * 63'(sg2_reg);
            for (int j = 3; j < LAT; j++)
            begin
                inv_reg[j] <= inv_reg[j-1];
            end
        end
    end

    logic [68:0] rem_reg [1:ND];
    logic [29:0] q_reg   [1:ND];
    logic [61:0] dv_reg  [1:ND];
    logic        ovf_reg [1:ND];

    for (genvar j = 1; j <= ND; j++)
    begin : g_div
        localparam int SH = ND - j;
        logic [68:0] rsrc;
        logic [29:0] qsrc;
        logic [61:0] dsrc;
        logic        osrc;
        logic [91:0] dsh;
        logic        take;
        if (j == 1)
        begin : g_first
            assign rsrc = rem3_reg;
            assign qsrc = '0;
            assign dsrc = dv3_reg;
            assign osrc = ovf3_reg;
        end
        else
        begin : g_rest
            assign rsrc = rem_reg[j-1];
            assign qsrc = q_reg[j-1];
            assign dsrc = dv_reg[j-1];
            assign osrc = ovf_reg[j-1];
        end
        assign dsh  = {30'b0, dsrc} << SH;
        assign take = {23'b0, rsrc} >= dsh;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= take ? 69'({23'b0, rsrc} - dsh) : rsrc;
                q_reg[j]   <= {qsrc[28:0], take};
                dv_reg[j]  <= dsrc;
                ovf_reg[j] <= osrc;
            end
        end
    end

    logic [29:0]        r34_reg;
    logic [41:0]        z35_reg;
    logic [41:0]        z36_reg;
    logic signed [31:0] lnk36;
    logic signed [44:0] lg37_reg;
    logic [59:0]        rsq;

    assign rsq = 60'(r34_reg) * 60'(r34_reg);

    snd_ln u_ln
    (
        .clk    (clk),
        .en     (en),
        .k_val  (k3_reg),
        .ln_val (lnk36)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r34_reg  <= (ovf_reg[ND] || q_reg[ND] > snd_pkg::RCAP) ? snd_pkg::RCAP : q_reg[ND];
            z35_reg  <= rsq[58:17];
            z36_reg  <= z35_reg;
            lg37_reg <= 45'(snd_pkg::HALF_LN_2_PI) - $signed({3'b0, z36_reg}) - 45'(lnk36);
        end
    end

    logic               neg38_reg;
    logic [36:0]        rm38_reg;
    logic [29:0]        sh38_reg;
    logic [44:0]        lg_mag;
    logic [44:0]        lg_rnd;
    logic               tiny_reg   [38:LAT-1];
    logic               huge_reg   [38:LAT-1];
    logic [31:0]        logres_reg [39:LAT-1];
    logic               logsat_reg [39:LAT-1];
    logic [31:0]        lres;
    logic               lsat;

    assign lg_mag = lg37_reg[44] ? 45'(-lg37_reg) : 45'(lg37_reg);
    assign lg_rnd = (lg_mag + 45'd128) >> 8;

    always_comb
    begin
        lres = rm38_reg[31:0];
        lsat = 1'b0;
        if (!neg38_reg)
        begin
            if (rm38_reg > 37'h0_7FFF_FFFF)
            begin
                lres = 32'h7FFF_FFFF;
                lsat = 1'b1;
            end
        end
        else if (rm38_reg > 37'h0_8000_0000)
        begin
            lres = 32'h8000_0000;
            lsat = 1'b1;
        end
        else
        begin
            lres = 32'(37'd0 - rm38_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg38_reg    <= lg37_reg[44];
            rm38_reg     <= lg_rnd[36:0];
            tiny_reg[38] <= lg37_reg < 45'(snd_pkg::TINY_LIMIT);
            huge_reg[38] <= lg37_reg >= 45'(snd_pkg::HUGE_LIMIT);
            sh38_reg     <= 30'(lg37_reg - 45'(snd_pkg::TINY_LIMIT));
            logres_reg[39] <= lres;
            logsat_reg[39] <= lsat;
            for (int j = 39; j < LAT; j++)
            begin
                tiny_reg[j] <= tiny_reg[j-1];
                huge_reg[j] <= huge_reg[j-1];
            end
            for (int j = 40; j < LAT; j++)
            begin
                logres_reg[j] <= logres_reg[j-1];
                logsat_reg[j] <= logsat_reg[j-1];
            end
        end
    end

    logic [29:0] qr_reg [1:6];
    logic [5:0]  qn_reg [1:6];

    for (genvar j = 1; j <= 6; j++)
    begin : g_nq
        localparam logic [29:0] STEP = 30'(snd_pkg::LN2_Q24 << (6 - j));
        logic [29:0] rsrc;
        logic [5:0]  qsrc;
        logic        take;
        if (j == 1)
        begin : g_first
            assign rsrc = sh38_reg;
            assign qsrc = '0;
        end
        else
        begin : g_rest
            assign rsrc = qr_reg[j-1];
            assign qsrc = qn_reg[j-1];
        end
        assign take = rsrc >= STEP;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qr_reg[j] <= take ? rsrc - STEP : rsrc;
                qn_reg[j] <= {qsrc[4:0], take};
            end
        end
    end

    logic [29:0] u45_reg;
    logic [5:0]  shamt_reg [45:LAT-1];
    logic [31:0] esum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u45_reg       <= {qr_reg[6][23:0], 6'b0};
            shamt_reg[45] <= 6'd54 - qn_reg[6];
            for (int j = 46; j < LAT; j++)
            begin
                shamt_reg[j] <= shamt_reg[j-1];
            end
        end
    end

    snd_exp u_exp
    (
        .clk     (clk),
        .en      (en),
        .u_val   (u45_reg),
        .sum_val (esum)
    );

    logic [5:0]  sa;
    logic [32:0] dv;
    logic [31:0] dres;
    logic        dsat;
    logic [31:0] ores;
    logic        oinv;
    logic        osat;

    assign sa = shamt_reg[LAT-1];
    assign dv = (sa == '0) ? 33'(esum) : (33'(esum >> (sa - 6'd1)) + 33'd1) >> 1;

    always_comb
    begin
        dres = dv[31:0];
        dsat = 1'b0;
        if (dv > 33'h0_7FFF_FFFF)
        begin
            dres = 32'h7FFF_FFFF;
            dsat = 1'b1;
        end
        oinv = 1'b0;
        if (inv_reg[LAT-1])
        begin
            ores = '0;
            osat = 1'b0;
            oinv = 1'b1;
        end
        else if (log_mode_reg)
        begin
            ores = logres_reg[LAT-1];
            osat = logsat_reg[LAT-1];
        end
        else if (tiny_reg[LAT-1])
        begin
            ores = '0;
            osat = 1'b0;
        end
        else if (huge_reg[LAT-1])
        begin
            ores = 32'h7FFF_FFFF;
            osat = 1'b1;
        end
        else
        begin
            ores = dres;
            osat = dsat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_axis_tdata <= ores;
            m_axis_tuser <= {osat, oinv};
        end
    end

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("invalid request gave a nonzero or saturated result");

    a_density_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !log_mode_reg && m_axis_tuser[1] |-> m_axis_tdata == 32'h7FFF_FFFF)
        else $error("saturated density is not the maximum value");

    a_log_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && log_mode_reg && m_axis_tuser[1]
        |-> m_axis_tdata == 32'h7FFF_FFFF || m_axis_tdata == 32'h8000_0000)
        else $error("saturated log density is not at a range limit");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for the split-normal density pipeline: directed and random requests checked
// against a bit-accurate predictor.
module tb;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_data;

    typedef struct packed {
        logic [31:0] density;
        logic        invalid;
        logic        sat;
    } density_t;

    density_t     pending_density[$];
    logic         mode_shadow;
    int           error_count;
    bit           stall_enable;

    split_normal_density dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint round_shift(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic logic [63:0] scaled_ratio(logic [63:0] a, int k, logic [63:0] b);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] bitv;
        q = 0;
        rem = 0;
        for (int i = 34 + k; i >= 0; i--)
        begin
            bitv = 0;
            if (i >= k && i - k < 64)
                bitv = (a >> (i - k)) & 64'd1;
            rem = (rem << 1) | bitv;
            if (q > snd_pkg::RCAP)
                q = snd_pkg::RCAP;
            q = q << 1;
            if (rem >= b)
            begin
                rem = rem - b;
                q = q | 64'd1;
            end
        end
        return (q > snd_pkg::RCAP) ? 64'(snd_pkg::RCAP) : q;
    endfunction

    function automatic longint natural_log_q32(logic [63:0] k);
        int          p;
        logic [63:0] m;
        logic [63:0] frac;
        longint      l2;
        p = 63;
        frac = 0;
        while (p > 0 && k[p] == 1'b0)
            p--;
        if (p >= 30)
            m = k >> (p - 30);
        else
            m = k << (30 - p);
        for (int i = 0; i < 24; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000)
            begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        l2 = longint'(p - 32) * (longint'(1) << 24) + longint'(frac);
        return round_shift(l2 * snd_pkg::LN2_Q30, 30);
    endfunction

    function automatic density_t predict_density(logic [127:0] req, logic lmode);
        density_t    d;
        longint      x;
        longint      mu;
        logic [63:0] sg;
        logic [63:0] lm;
        logic [63:0] r;
        logic [63:0] z;
        longint      lg;
        longint      res;
        logic [63:0] sh;
        int          n;
        logic [63:0] u;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        int          s;
        x = longint'($signed(req[31:0]));
        mu = longint'($signed(req[63:32]));
        sg = 64'(req[94:64]);
        lm = 64'(req[125:95]);
        d = '0;
        if (sg == 0 || lm == 0)
        begin
            d.invalid = 1'b1;
            return d;
        end
        if (x <= mu)
            r = scaled_ratio(64'(mu - x), 20, sg);
        else
            r = scaled_ratio(64'(x - mu), 36, sg * lm);
        z = (r * r) >> 17;
        lg = snd_pkg::HALF_LN_2_PI - longint'(z) - natural_log_q32((64'd65536 + lm) * sg);
        if (lmode)
        begin
            res = round_shift(lg, 8);
            if (res > 64'sd2147483647)
            begin
                res = 64'sd2147483647;
                d.sat = 1'b1;
            end
            if (res < -64'sd2147483648)
            begin
                res = -64'sd2147483648;
                d.sat = 1'b1;
            end
        end
        else if (lg < snd_pkg::TINY_LIMIT)
            res = 0;
        else if (lg >= snd_pkg::HUGE_LIMIT)
        begin
            res = 64'sd2147483647;
            d.sat = 1'b1;
        end
        else
        begin
            sh = 64'(lg - snd_pkg::TINY_LIMIT);
            n = int'(sh / 64'(snd_pkg::LN2_Q24)) - 40;
            u = (sh % 64'(snd_pkg::LN2_Q24)) << 6;
            term = 64'd1 << 30;
            sum = term;
            for (int k = 1; k <= 13; k++)
            begin
                term = ((term * u) >> 30) / 64'(k);
                sum = sum + term;
            end
            s = 14 - n;
            v = (s != 0) ? (sum + (64'd1 << (s - 1))) >> s : sum;
            if (v > 64'h7FFF_FFFF)
            begin
                v = 64'h7FFF_FFFF;
                d.sat = 1'b1;
            end
            res = longint'(v);
        end
        d.density = res[31:0];
        return d;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int random_gap();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random back-pressure while stall_enable is set and checking of every result.
    initial
    begin
        density_t got;
        density_t want;
        int       hold;
        hold = 0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.density = m_axis_tdata;
                got.invalid = m_axis_tuser[0];
                got.sat = m_axis_tuser[1];
                if (pending_density.size() == 0)
                    report_mismatch("unexpected result", m_axis_tdata, 32'd0);
                else
                begin
                    want = pending_density.pop_front();
                    if (got.density !== want.density)
                        report_mismatch("density_value", got.density, want.density);
                    if (got.invalid !== want.invalid)
                        report_mismatch("invalid_args", 32'(got.invalid), 32'(want.invalid));
                    if (got.sat !== want.sat)
                        report_mismatch("saturated", 32'(got.sat), 32'(want.sat));
                end
            end
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = stall_enable ? random_gap() : 0;
            end
        end
    end

    task automatic send_request(logic [31:0] x, logic [31:0] mu, logic [30:0] sg,
                                logic [30:0] lm);
        int gap;
        gap = stall_enable ? random_gap() : 0;
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, lm, sg, mu, x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_density.push_back(predict_density({2'b00, lm, sg, mu, x}, mode_shadow));
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (pending_density.size() != 0)
            @(posedge clk);
        repeat (snd_pkg::PIPE_LAT + 10) @(posedge clk);
    endtask

    task automatic write_log_mode(logic value);
        drain_pipe();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        mode_shadow = value;
    endtask

    task automatic random_request(int scale_kind);
        logic [31:0] x;
        logic [31:0] mu;
        logic [30:0] sg;
        logic [30:0] lm;
        x = $urandom;
        mu = $urandom;
        sg = 31'($urandom);
        lm = 31'($urandom);
        if (scale_kind < 6)
        begin
            // Values near the mode with moderate scales reach the series evaluation.
            mu = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            x = mu + $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
            sg = 31'($urandom_range(32'h0000_1000, 32'h0004_0000));
            lm = 31'($urandom_range(32'h0000_1000, 32'h0004_0000));
        end
        else if (scale_kind == 6)
            sg = 0;
        else if (scale_kind == 7)
            lm = 0;
        else if (scale_kind == 8)
        begin
            sg = 31'($urandom_range(1, 64));
            lm = 31'($urandom_range(1, 64));
            x = mu;
        end
        send_request(x, mu, sg, lm);
    endtask

    task automatic test_directed(logic lmode);
        write_log_mode(lmode);
        send_request(32'h0000_0000, 32'h0000_0000, 31'h0001_0000, 31'h0001_0000);
        send_request(32'h0001_0000, 32'h0000_0000, 31'h0001_0000, 31'h0002_0000);
        send_request(32'hFFFF_0000, 32'h0000_0000, 31'h0001_0000, 31'h0002_0000);
        send_request(32'h7FFF_FFFF, 32'h8000_0000, 31'h0000_0001, 31'h0000_0001);
        send_request(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_request(32'h8000_0000, 32'h7FFF_FFFF, 31'h0000_0001, 31'h7FFF_FFFF);
        send_request(32'h1234_5678, 32'h1234_5678, 31'h0000_0000, 31'h0001_0000);
        send_request(32'h1234_5678, 32'h1234_5678, 31'h0001_0000, 31'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h0000_0000, 31'h0000_0000);
        send_request(32'h0000_0000, 32'h0000_0000, 31'h0000_0001, 31'h0000_0001);
        send_request(32'h0000_0000, 32'h0000_0000, 31'h0000_0010, 31'h0000_0010);
        send_request(32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_request(32'h0050_0000, 32'h0000_0000, 31'h0001_0000, 31'h0001_0000);
        send_request(32'h0000_0001, 32'h0000_0000, 31'h0000_0100, 31'h0000_0100);
        send_request(32'h0000_0000, 32'h0000_0001, 31'h0000_0100, 31'h0000_0100);
    endtask

    task automatic test_random(int count, logic lmode);
        write_log_mode(lmode);
        for (int i = 0; i < count; i++)
            random_request($urandom_range(0, 9));
    endtask

    task automatic test_pause_until_empty();
        for (int i = 0; i < 20; i++)
            random_request(0);
        s_axis_tvalid <= 1'b0;
        while (pending_density.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 20; i++)
            random_request(0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        mode_shadow = 1'b0;
        error_count = 0;
        stall_enable = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed(1'b0);
        test_directed(1'b1);
        test_random(200, 1'b0);
        test_random(200, 1'b1);
        stall_enable = 1'b0;
        test_random(100, 1'b0);
        stall_enable = 1'b1;
        test_pause_until_empty();
        test_random(120, 1'b1);
        drain_pipe();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
